[rtl/itra_pkg.sv]
// ----------------------------------------------------------------------------
// itra_pkg
// Shared widths, character codes, controller state, command and status types
// for the integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package itra_pkg;

	localparam int VALUE_W        = 32;
	localparam int BASE_W         = 6;
	localparam int CFG_W          = 6;
	localparam int CHAR_W         = 7;
	localparam int DIG_W          = 6;
	localparam int BITCNT_W       = $clog2(VALUE_W);
	localparam int MAX_DIGITS_DEF = 32;

	localparam logic [BASE_W-1:0] BASE_MIN    = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX    = BASE_W'(36);
	localparam logic [CFG_W-1:0]  LIMIT_RESET = CFG_W'(32);
	localparam logic [DIG_W-1:0]  DEC_MAX     = DIG_W'(9);
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2D;
	localparam logic [CHAR_W-1:0] ALPHA_GAP   = CHAR_W'(7);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic store;
		logic read;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic div_done;
		logic more;
		logic cnt_zero;
	} sts_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
		logic [CHAR_W-1:0] c;
		c = CHAR_ZERO + CHAR_W'(d);
		if (d > DEC_MAX) begin
			c = c + ALPHA_GAP;
		end
		return c;
	endfunction

endpackage

[rtl/integer_to_radix_ascii.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Sequence: a load, then per digit 32 bit-serial divider steps and a store, then
// the sign beat for a negative value and a read and an emit per digit. The block
// takes one value at a time; the next start is taken the cycle after the last
// beat. The receiver cannot stall: each beat shows for one cycle. Reset is
// asynchronous; it idles the block and sets the limit to 32.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
	parameter int MAX_DIGITS = itra_pkg::MAX_DIGITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [itra_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [itra_pkg::VALUE_W-1:0] value,
	input  logic [itra_pkg::BASE_W-1:0]         base,
	output logic                                strobe,
	output logic [itra_pkg::CHAR_W-1:0]         character,
	output logic                                last
);
	import itra_pkg::*;

	cmd_t cmd;
	sts_t sts;

	itra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	itra_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.value       (value),
		.base        (base),
		.cmd         (cmd),
		.sts         (sts),
		.strobe      (strobe),
		.character   (character),
		.last        (last)
	);

endmodule

[rtl/itra_ctrl.sv]
// ----------------------------------------------------------------------------
// itra_ctrl
// Sequencer: load, one divider step per cycle, digit store, sign and
// character emission.
// ----------------------------------------------------------------------------
module itra_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  itra_pkg::sts_t sts,
	output itra_pkg::cmd_t cmd,
	output logic          busy
);
	import itra_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_nxt = ST_STORE;
			end
			ST_STORE: begin
				if (sts.more)     state_nxt = ST_DIV;
				else if (sts.neg) state_nxt = ST_SIGN;
				else              state_nxt = ST_READ;
			end
			ST_SIGN: state_nxt = ST_READ;
			ST_READ: state_nxt = ST_EMIT;
			ST_EMIT: begin
				// the beat with count at zero is the last digit
				if (sts.cnt_zero) state_nxt = ST_IDLE;
				else              state_nxt = ST_READ;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DIV:   cmd.div_step   = 1'b1;
			ST_STORE: cmd.store      = 1'b1;
			ST_SIGN:  cmd.emit_sign  = 1'b1;
			ST_READ:  cmd.read       = 1'b1;
			ST_EMIT:  cmd.emit_digit = 1'b1;
			default:  busy           = 1'b1;
		endcase
	end

endmodule

[rtl/itra_dp.sv]
// ----------------------------------------------------------------------------
// itra_dp
// Datapath: magnitude and radix registers, bit-serial restoring divider,
// digit memory and character encoder, plus the digit limit register.
// ----------------------------------------------------------------------------
module itra_dp #(
	parameter int MAX_DIGITS = itra_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [itra_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic signed [itra_pkg::VALUE_W-1:0] value,
	input  logic [itra_pkg::BASE_W-1:0]   base,
	input  itra_pkg::cmd_t                cmd,
	output itra_pkg::sts_t                sts,
	output logic                          strobe,
	output logic [itra_pkg::CHAR_W-1:0]   character,
	output logic                          last
);
	import itra_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [CFG_W-1:0] LIM_MAX = CFG_W'(MAX_DIGITS);

	logic [CFG_W-1:0]    digit_limit_q;
	logic [CNT_W-1:0]    lim_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic [VALUE_W-1:0]  quot_q;
	logic [DIG_W-1:0]    rem_q;
	logic [BASE_W-1:0]   base_q;
	logic                neg_q;
	logic [DIG_W-1:0]    rd_data_q;
	logic [DIG_W-1:0]    mem_q [MAX_DIGITS];

	logic [VALUE_W-1:0] raw;
	logic [VALUE_W-1:0] mag;
	logic [BASE_W-1:0]  base_clamp;
	logic [CFG_W-1:0]   lim_clamp;
	logic [DIG_W:0]     trial;
	logic               ge;
	logic [DIG_W:0]     trial_sub;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   cnt_dec;

	assign raw = unsigned'(value);
	assign mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

	always_comb begin
		base_clamp = base;
		if (base < BASE_MIN)      base_clamp = BASE_MIN;
		else if (base > BASE_MAX) base_clamp = BASE_MAX;
		lim_clamp = digit_limit_q;
		if (digit_limit_q == '0)          lim_clamp = CFG_W'(1);
		else if (digit_limit_q > LIM_MAX) lim_clamp = LIM_MAX;
	end

	// one quotient bit per cycle; remainder stays below the base
	assign trial     = {rem_q, quot_q[VALUE_W-1]};
	assign ge        = trial >= {1'b0, base_q};
	assign trial_sub = trial - {1'b0, base_q};
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign cnt_dec   = cnt_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			digit_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			bit_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q     <= '0;
				bit_cnt_q <= '0;
			end
			if (cmd.div_step) bit_cnt_q <= bit_cnt_q + BITCNT_W'(1);
			if (cmd.store) begin
				cnt_q     <= cnt_inc;
				bit_cnt_q <= '0;
			end
			if (cmd.read) cnt_q <= cnt_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q <= mag;
			rem_q  <= '0;
			base_q <= base_clamp;
			neg_q  <= raw[VALUE_W-1];
			lim_q  <= CNT_W'(lim_clamp);
		end
		if (cmd.div_step) begin
			quot_q <= {quot_q[VALUE_W-2:0], ge};
			rem_q  <= ge ? trial_sub[DIG_W-1:0] : trial[DIG_W-1:0];
		end
		if (cmd.store) rem_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.store) mem_q[cnt_q[AW-1:0]] <= rem_q;
		if (cmd.read)  rd_data_q <= mem_q[cnt_dec[AW-1:0]];
	end

	assign sts.neg      = neg_q;
	assign sts.div_done = bit_cnt_q == BITCNT_W'(VALUE_W - 1);
	assign sts.more     = (quot_q != '0) && (cnt_inc < lim_q);
	assign sts.cnt_zero = cnt_q == '0;

	assign strobe    = cmd.emit_sign | cmd.emit_digit;
	assign character = cmd.emit_sign ? CHAR_MINUS : digit_char(rd_data_q);
	assign last      = cmd.emit_digit & (cnt_q == '0);

endmodule

[dv/integer_to_radix_ascii_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_test
// Drives signed integers and bases into the converter through the start/busy
// handshake, predicts the character stream for each accepted number and
// checks every strobed character and its last flag in order. The digit limit
// is rewritten between phases while the block is idle, covering the clamped
// and saturated settings.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_test;
	import itra_pkg::*;

	localparam int                STALL_LIMIT  = 6000;
	localparam int                DRAIN_CYCLES = 8;
	localparam int                PRINT_CAP    = 40;
	localparam logic [CHAR_W-1:0] CHAR_A       = 7'h41;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [BASE_W-1:0]         base;
	} number_t;

	typedef struct {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_beat_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]          cfg_wr_data = '0;
	logic                      start       = 1'b0;
	logic                      busy;
	logic signed [VALUE_W-1:0] value       = '0;
	logic [BASE_W-1:0]         base        = BASE_W'(10);
	logic                      strobe;
	logic [CHAR_W-1:0]         character;
	logic                      last;

	number_t          number_q[$];
	text_beat_t       text_q[$];
	logic [CFG_W-1:0] limit_reg = LIMIT_RESET;
	int               gap_left  = 0;
	bit               steady    = 1'b0;
	int               err_cnt   = 0;
	int               stall_cnt = 0;

	integer_to_radix_ascii u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.base        (base),
		.strobe      (strobe),
		.character   (character),
		.last        (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (err_cnt < PRINT_CAP) begin
			$display("%0t ERROR: %s", $time, msg);
		end
		err_cnt++;
	endtask

	// Expected text of one number under the current digit limit.
	task automatic predict_text(input logic signed [VALUE_W-1:0] v,
			input logic [BASE_W-1:0] b);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] radix;
		int                 cap;
		logic [DIG_W-1:0]   digs[$];
		text_beat_t         beat;
		mag = v;
		if (v[VALUE_W-1]) begin
			mag = ~mag + 1'b1;
		end
		radix = (b < BASE_MIN) ? BASE_MIN : (b > BASE_MAX) ? BASE_MAX : b;
		cap = (limit_reg == 0) ? 1 :
			(limit_reg > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : int'(limit_reg);
		// Keep the low-order digits only, at least one.
		do begin
			digs.push_front(DIG_W'(mag % radix));
			mag = mag / radix;
		end while (mag != 0 && digs.size() < cap);
		if (v[VALUE_W-1]) begin
			beat.character = CHAR_MINUS;
			beat.last = 1'b0;
			text_q.push_back(beat);
		end
		foreach (digs[i]) begin
			if (digs[i] <= DEC_MAX) begin
				beat.character = CHAR_ZERO + CHAR_W'(digs[i]);
			end else begin
				beat.character = CHAR_A + CHAR_W'(digs[i]) - CHAR_W'(10);
			end
			beat.last = (i == digs.size() - 1);
			text_q.push_back(beat);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(20, 150);
	endfunction

	task automatic add_number(input logic signed [VALUE_W-1:0] v,
			input logic [BASE_W-1:0] b);
		number_t n;
		n.value = v;
		n.base = b;
		number_q.push_back(n);
	endtask

	task automatic add_directed();
		add_number(32'sd0, 6'd10);
		add_number(-32'sd1, 6'd10);
		add_number(32'sh8000_0000, 6'd2);
		add_number(32'sh8000_0000, 6'd36);
		add_number(32'sh7FFF_FFFF, 6'd2);
		add_number(32'sh7FFF_FFFF, 6'd36);
		add_number(32'sd35, 6'd36);
		add_number(-32'sd35, 6'd36);
		add_number(32'sd1295, 6'd36);
		add_number(32'sd9, 6'd10);
		add_number(32'sd10, 6'd16);
		add_number(-32'sd255, 6'd16);
		add_number(32'sd123456789, 6'd10);
		add_number(32'sd7, 6'd0);
		add_number(32'sd7, 6'd1);
		add_number(32'sd100, 6'd37);
		add_number(-32'sd100, 6'd63);
		add_number(32'sd0, 6'd63);
	endtask

	task automatic add_random(input int count);
		int                        r;
		logic [BASE_W-1:0]         b;
		logic signed [VALUE_W-1:0] v;
		// Open with a long negative so truncation meets the sign.
		add_number(-$signed(32'($urandom_range(1 << 20, 32'h7FFF_FFFF))), 6'd2);
		repeat (count - 1) begin
			b = ($urandom_range(0, 99) < 88) ? BASE_W'($urandom_range(2, 36)) :
				BASE_W'($urandom_range(0, 63));
			r = $urandom_range(0, 99);
			if (r < 35) begin
				v = $urandom;
			end else if (r < 55) begin
				v = $urandom_range(0, 1000);
			end else if (r < 70) begin
				// lowest digit equals base minus one
				v = $urandom_range(0, 50000) * ((b < 2) ? 2 : (b > 36) ? 36 : b);
				v = v + ((b < 2) ? 1 : (b > 36) ? 35 : b - 1);
			end else if (r < 80) begin
				case ($urandom_range(0, 5))
					0: v = 32'sh8000_0000;
					1: v = 32'sh8000_0001;
					2: v = 32'sh7FFF_FFFF;
					3: v = -32'sd1;
					4: v = 32'sd1;
					default: v = 32'sd0;
				endcase
			end else begin
				v = $urandom >> $urandom_range(0, 31);
			end
			if (r >= 35 && r < 70 && $urandom_range(0, 1)) begin
				v = -v;
			end
			add_number(v, b);
		end
	endtask

	task automatic drain();
		while (number_q.size() != 0 || start || text_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] lim);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lim;
		limit_reg = lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	always @(posedge clk) begin : driver
		number_t nxt;
		logic    start_nxt;
		if (arst_n) begin
			start_nxt = start;
			if (start && !busy) begin
				predict_text(value, base);
				start_nxt = 1'b0;
			end
			if (!start_nxt) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
				end else if (number_q.size() != 0) begin
					nxt = number_q.pop_front();
					value <= nxt.value;
					base <= nxt.base;
					start_nxt = 1'b1;
					gap_left = pick_gap();
				end
			end
			// hold start across busy cycles; drop it only after the beat
			start <= start_nxt;
		end
	end

	always @(posedge clk) begin : monitor
		text_beat_t want;
		if (arst_n && strobe) begin
			if (text_q.size() == 0) begin
				report_mismatch($sformatf("unexpected character %h", character));
			end else begin
				want = text_q.pop_front();
				if (character !== want.character) begin
					report_mismatch($sformatf("character %h, expected %h",
						character, want.character));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("last %b, expected %b on character %h",
						last, want.last, want.character));
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((start && !busy) || strobe) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0] limits[8];
		limits = '{6'd1, 6'd0, 6'd63, 6'd33, 6'd3, 6'd10, 6'd32, 6'd17};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		add_directed();
		drain();
		foreach (limits[i]) begin
			write_limit(limits[i]);
			steady = (i % 3 == 1);
			add_random(25);
			drain();
		end
		if (err_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/itra_pkg.sv
rtl/itra_ctrl.sv
rtl/itra_dp.sv
rtl/integer_to_radix_ascii.sv
dv/integer_to_radix_ascii_test.sv
